// File: hdl/ssl_pkg.sv
// shared types, constants and control/status structs of the serial s-record loader
// no dependencies; used by ssl_ctrl, ssl_dp and serial_srecord_loader
package ssl_pkg;

  localparam int unsigned LINE_CHARS_DEF    = 128;
  localparam int unsigned DECODED_BYTES_DEF = 64;
  localparam int unsigned IDX_W             = 9;
  localparam int unsigned MAX_WRITES        = 62;
  localparam int unsigned OUT_TDATA_W       = 48;

  localparam logic [31:0] ADDR_MASK = 32'h1FFF_FFFF;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_W  = 8'h57;
  localparam logic [7:0] CH_R  = 8'h52;
  localparam logic [7:0] CH_E  = 8'h45;
  localparam logic [7:0] CH_D  = 8'h44;
  localparam logic [7:0] CH_L  = 8'h4C;
  localparam logic [7:0] CH_B  = 8'h42;
  localparam logic [7:0] CH_N  = 8'h4E;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_1  = 8'h31;
  localparam logic [7:0] CH_2  = 8'h32;
  localparam logic [7:0] CH_3  = 8'h33;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_LX = 8'h78;
  localparam logic [7:0] CH_LE = 8'h65;
  localparam logic [7:0] CH_LM = 8'h6D;

  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_FLASH = 2'd2;

  localparam logic CFG_RAM_BASE = 1'b0;
  localparam logic CFG_RAM_END  = 1'b1;

  typedef enum logic [1:0] {
    MODE_WAIT = 2'd0,
    MODE_WR   = 2'd1,
    MODE_DL   = 2'd2,
    MODE_BW   = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_ECHO, ST_FLASH, ST_TX_W, ST_TX_R, ST_TX_E, ST_TX_LF,
    ST_RD_CHAR, ST_PROC, ST_FLUSH, ST_CHECK, ST_SUM_HI, ST_SUM_LO, ST_TX_M,
    ST_WR_CHK, ST_WR_EMIT, ST_TX_X, ST_TX_END
  } state_e;

  typedef enum logic [2:0] {
    SRC_RX, SRC_CHR, SRC_SUM_HI, SRC_SUM_LO, SRC_FLASH, SRC_WRITE
  } src_e;

  typedef struct packed {
    logic       take;
    logic       cmd_store;
    logic       cmd_clear;
    logic       rec_store;
    logic       rec_clear;
    logic       hi_clear;
    logic       walk_init;
    logic       rd_char;
    logic       proc_char;
    logic       flush;
    logic       wr_init;
    logic       wr_rd;
    logic       hi_update;
    logic       emit;
    src_e       src;
    logic [7:0] chr;
    logic       last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rx_lf;
    logic cmd_full;
    logic match_wr;
    logic match_dl;
    logic match_bw;
    logic rec_end;
    logic rec_srec;
    logic s_done;
    logic char_zero;
    logic pending;
    logic sum_ok;
    logic wr_more;
    logic out_free;
  } dp_stat_t;

endpackage

// File: hdl/ssl_ctrl.sv
// controller state machine of the serial s-record loader: mode and sequencing
// depends on ssl_pkg
module ssl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ssl_pkg::dp_stat_t st_i,
  output ssl_pkg::ctrl_cmd_t cmd_o
);
  import ssl_pkg::*;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MODE_WAIT;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // next state and mode
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        case (mode_q)
          MODE_WAIT: begin
            if (st_i.rx_lf) begin
              if (st_i.match_wr)      mode_d = MODE_WR;
              else if (st_i.match_dl) mode_d = MODE_DL;
              else if (st_i.match_bw) mode_d = MODE_BW;
              state_d = ST_ECHO;
            end else if (!st_i.cmd_full) begin
              state_d = ST_ECHO;
            end else begin
              state_d = ST_IDLE;
            end
          end
          MODE_WR: begin
            mode_d  = MODE_WAIT;
            state_d = ST_FLASH;
          end
          MODE_DL: begin
            if (!st_i.rx_lf) begin
              state_d = ST_IDLE;
            end else if (st_i.rec_end) begin
              mode_d  = MODE_WAIT;
              state_d = ST_TX_END;
            end else if (!st_i.rec_srec) begin
              state_d = ST_TX_X;
            end else begin
              state_d = ST_RD_CHAR;
            end
          end
          default: begin
            mode_d  = MODE_WAIT;
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_ECHO:    if (st_i.out_free) state_d = ST_IDLE;
      ST_FLASH:   if (st_i.out_free) state_d = ST_TX_W;
      ST_TX_W:    if (st_i.out_free) state_d = ST_TX_R;
      ST_TX_R:    if (st_i.out_free) state_d = ST_TX_E;
      ST_TX_E:    if (st_i.out_free) state_d = ST_TX_LF;
      ST_TX_LF:   if (st_i.out_free) state_d = ST_IDLE;
      ST_RD_CHAR: state_d = st_i.s_done ? ST_FLUSH : ST_PROC;
      ST_PROC:    state_d = st_i.char_zero ? ST_FLUSH : ST_RD_CHAR;
      ST_FLUSH:   state_d = ST_CHECK;
      ST_CHECK: begin
        if (st_i.sum_ok) begin
          state_d = ST_WR_CHK;
        end else begin
          mode_d  = MODE_WAIT;
          state_d = ST_SUM_HI;
        end
      end
      ST_SUM_HI:  if (st_i.out_free) state_d = ST_SUM_LO;
      ST_SUM_LO:  if (st_i.out_free) state_d = ST_TX_M;
      ST_TX_M:    if (st_i.out_free) state_d = ST_TX_LF;
      ST_WR_CHK:  state_d = st_i.wr_more ? ST_WR_EMIT : ST_TX_X;
      ST_WR_EMIT: if (st_i.out_free) state_d = ST_WR_CHK;
      ST_TX_X:    if (st_i.out_free) state_d = ST_TX_LF;
      ST_TX_END:  if (st_i.out_free) state_d = ST_TX_LF;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o     = '0;
    cmd_o.src = SRC_CHR;
    case (state_q)
      ST_IDLE: cmd_o.take = in_valid_i;
      ST_DISPATCH: begin
        case (mode_q)
          MODE_WAIT: begin
            if (st_i.rx_lf) begin
              cmd_o.cmd_clear = 1'b1;
              cmd_o.hi_clear  = !st_i.match_wr && st_i.match_dl;
            end else begin
              cmd_o.cmd_store = !st_i.cmd_full;
            end
          end
          MODE_DL: begin
            if (!st_i.rx_lf) begin
              cmd_o.rec_store = 1'b1;
            end else if (st_i.rec_end || !st_i.rec_srec) begin
              cmd_o.rec_clear = 1'b1;
            end else begin
              cmd_o.walk_init = 1'b1;
            end
          end
          MODE_BW:  cmd_o.cmd_clear = 1'b1;
          default:  cmd_o.take = 1'b0;
        endcase
      end
      ST_ECHO: begin
        cmd_o.emit = st_i.out_free;
        cmd_o.src  = SRC_RX;
        cmd_o.last = 1'b1;
      end
      ST_FLASH: begin
        cmd_o.emit = st_i.out_free;
        cmd_o.src  = SRC_FLASH;
      end
      ST_TX_W: begin
        cmd_o.emit = st_i.out_free;
        cmd_o.chr  = CH_W;
      end
      ST_TX_R: begin
        cmd_o.emit = st_i.out_free;
        cmd_o.chr  = CH_R;
      end
      ST_TX_E: begin
        cmd_o.emit = st_i.out_free;
        cmd_o.chr  = CH_E;
      end
      ST_TX_LF: begin
        cmd_o.emit = st_i.out_free;
        cmd_o.chr  = CH_LF;
        cmd_o.last = 1'b1;
      end
      ST_RD_CHAR: cmd_o.rd_char = !st_i.s_done;
      ST_PROC:    cmd_o.proc_char = !st_i.char_zero;
      ST_FLUSH:   cmd_o.flush = st_i.pending;
      ST_CHECK: begin
        cmd_o.rec_clear = 1'b1;
        cmd_o.wr_init   = st_i.sum_ok;
      end
      ST_SUM_HI: begin
        cmd_o.emit = st_i.out_free;
        cmd_o.src  = SRC_SUM_HI;
      end
      ST_SUM_LO: begin
        cmd_o.emit = st_i.out_free;
        cmd_o.src  = SRC_SUM_LO;
      end
      ST_TX_M: begin
        cmd_o.emit = st_i.out_free;
        cmd_o.chr  = CH_LM;
      end
      ST_WR_CHK: begin
        cmd_o.wr_rd     = st_i.wr_more;
        cmd_o.hi_update = !st_i.wr_more;
      end
      ST_WR_EMIT: begin
        cmd_o.emit = st_i.out_free;
        cmd_o.src  = SRC_WRITE;
      end
      ST_TX_X: begin
        cmd_o.emit = st_i.out_free;
        cmd_o.chr  = CH_LX;
      end
      ST_TX_END: begin
        cmd_o.emit = st_i.out_free;
        cmd_o.chr  = CH_LE;
      end
      default: cmd_o.take = 1'b0;
    endcase
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> st_i.out_free) else $error("result loaded into a full output register");
  a_proc_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PROC |-> $past(state_q) == ST_RD_CHAR)
    else $error("character processed without a read");
  a_dispatch_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DISPATCH |-> $past(state_q) == ST_IDLE && $past(in_valid_i))
    else $error("dispatch without an accepted byte");

endmodule

// File: hdl/ssl_dp.sv
// datapath of the serial s-record loader: line buffers, hex decode, sum, writes, output register
// depends on ssl_pkg; driven by ssl_ctrl
module ssl_dp #(
  parameter int unsigned LINE_CHARS    = ssl_pkg::LINE_CHARS_DEF,
  parameter int unsigned DECODED_BYTES = ssl_pkg::DECODED_BYTES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [7:0]                          rx_byte_i,
  input  logic [31:0]                         ram_base_i,
  input  logic [31:0]                         ram_end_i,
  input  ssl_pkg::ctrl_cmd_t                  cmd_i,
  output ssl_pkg::dp_stat_t                   st_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ssl_pkg::OUT_TDATA_W-1:0]     out_data_o,
  output logic                                out_last_o
);
  import ssl_pkg::*;

  localparam int unsigned LW = $clog2(LINE_CHARS + 1);
  localparam int unsigned LA = $clog2(LINE_CHARS);
  localparam int unsigned DW = $clog2(DECODED_BYTES);

  logic [7:0]  rx_q;
  logic [LW-1:0] cmd_cnt_q;
  logic [7:0]  cmd0_q, cmd1_q;
  logic [LW-1:0] rec_cnt_q;
  logic [7:0]  rec0_q, rec1_q, rec2_q;
  logic [7:0]  rec_mem [LINE_CHARS];
  logic [7:0]  rd_q;
  logic [LW-1:0] s_q;
  logic [IDX_W-1:0] d_q, dval_q, i_q;
  logic [7:0]  dmem [DECODED_BYTES];
  logic [7:0]  rdd_q;
  logic [7:0]  hi_q, len_q;
  logic        pend_q;
  logic [15:0] sum_q;
  logic [31:0] addr_q, waddr_q, high_q;
  logic [2:0]  abytes_q;
  logic [5:0]  nwr_q;

  logic        out_valid_q, out_last_q;
  logic [1:0]  out_kind_q;
  logic [7:0]  out_byte_q;
  logic [31:0] out_addr_q;

  // hex digit and byte completion
  logic [7:0]  nib, cbyte, be;
  logic        complete, d_in;
  logic [1:0]  sh;
  logic [31:0] wclamp;
  logic [7:0]  wval;

  assign nib = (rd_q < CH_UA) ? {4'h0, rd_q[3:0]} : ({4'h0, rd_q[3:0]} + 8'd9);
  assign complete = (cmd_i.proc_char && s_q[0]) || cmd_i.flush;
  assign cbyte = cmd_i.flush ? hi_q : (hi_q + nib);
  assign d_in = d_q < IDX_W'(DECODED_BYTES);
  assign be = d_in ? cbyte : 8'h00;
  assign sh = 2'(abytes_q - d_q[2:0]);
  assign wclamp = (waddr_q > ram_end_i) ? ram_end_i : waddr_q;
  assign wval = (i_q < dval_q && i_q < IDX_W'(DECODED_BYTES)) ? rdd_q : 8'h00;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) rx_q <= rx_byte_i;
    if (cmd_i.rec_store && rec_cnt_q != LW'(LINE_CHARS)) rec_mem[rec_cnt_q[LA-1:0]] <= rx_q;
    if (cmd_i.rd_char) rd_q <= rec_mem[s_q[LA-1:0]];
    if (complete && d_in) dmem[d_q[DW-1:0]] <= cbyte;
    if (cmd_i.wr_rd) rdd_q <= dmem[i_q[DW-1:0]];
    if (cmd_i.emit) begin
      out_last_q <= cmd_i.last;
      case (cmd_i.src)
        SRC_RX: begin
          out_kind_q <= KIND_TX;
          out_byte_q <= rx_q;
          out_addr_q <= '0;
        end
        SRC_SUM_HI: begin
          out_kind_q <= KIND_TX;
          out_byte_q <= sum_q[15:8];
          out_addr_q <= '0;
        end
        SRC_SUM_LO: begin
          out_kind_q <= KIND_TX;
          out_byte_q <= sum_q[7:0];
          out_addr_q <= '0;
        end
        SRC_FLASH: begin
          out_kind_q <= KIND_FLASH;
          out_byte_q <= '0;
          out_addr_q <= high_q - ram_base_i;
        end
        SRC_WRITE: begin
          out_kind_q <= KIND_WRITE;
          out_byte_q <= wval;
          out_addr_q <= wclamp;
        end
        default: begin
          out_kind_q <= KIND_TX;
          out_byte_q <= cmd_i.chr;
          out_addr_q <= '0;
        end
      endcase
    end
    // decode walk
    if (cmd_i.walk_init) begin
      s_q      <= LW'(2);
      sum_q    <= '0;
      addr_q   <= '0;
      len_q    <= '0;
      abytes_q <= 3'(rec1_q[1:0]) + 3'd1;
    end else if (cmd_i.proc_char) begin
      s_q <= s_q + LW'(1);
      if (!s_q[0]) hi_q <= {nib[3:0], 4'h0};
    end
    if (complete) begin
      if (d_q == '0) begin
        len_q <= be;
        sum_q <= sum_q + {8'h00, be};
      end else if (d_q <= {1'b0, len_q}) begin
        sum_q <= sum_q + {8'h00, be};
      end
      if (d_q != '0 && d_q <= IDX_W'(abytes_q))
        addr_q <= addr_q | ({24'h0, be} << {sh, 3'b000});
    end
    // record writes
    if (cmd_i.wr_init) begin
      i_q     <= IDX_W'(abytes_q) + IDX_W'(1);
      waddr_q <= (addr_q & ADDR_MASK) + ram_base_i;
      nwr_q   <= '0;
    end else if (cmd_i.emit && cmd_i.src == SRC_WRITE) begin
      i_q     <= i_q + IDX_W'(1);
      waddr_q <= wclamp + 32'd1;
      nwr_q   <= nwr_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_cnt_q   <= '0;
      cmd0_q      <= '0;
      cmd1_q      <= '0;
      rec_cnt_q   <= '0;
      rec0_q      <= '0;
      rec1_q      <= '0;
      rec2_q      <= '0;
      d_q         <= '0;
      dval_q      <= '0;
      pend_q      <= 1'b0;
      high_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cmd_clear) begin
        cmd_cnt_q <= '0;
        cmd0_q    <= '0;
        cmd1_q    <= '0;
      end else if (cmd_i.cmd_store) begin
        cmd_cnt_q <= cmd_cnt_q + LW'(1);
        if (cmd_cnt_q == LW'(0)) cmd0_q <= rx_q;
        if (cmd_cnt_q == LW'(1)) cmd1_q <= rx_q;
      end
      if (cmd_i.rec_clear) begin
        rec_cnt_q <= '0;
        rec0_q    <= '0;
        rec1_q    <= '0;
        rec2_q    <= '0;
      end else if (cmd_i.rec_store && rec_cnt_q != LW'(LINE_CHARS)) begin
        rec_cnt_q <= rec_cnt_q + LW'(1);
        if (rec_cnt_q == LW'(0)) rec0_q <= rx_q;
        if (rec_cnt_q == LW'(1)) rec1_q <= rx_q;
        if (rec_cnt_q == LW'(2)) rec2_q <= rx_q;
      end
      if (cmd_i.walk_init) begin
        d_q    <= '0;
        dval_q <= '0;
        pend_q <= 1'b0;
      end else begin
        if (cmd_i.proc_char) pend_q <= !s_q[0];
        if (cmd_i.flush) pend_q <= 1'b0;
        if (cmd_i.proc_char && s_q[0]) d_q <= d_q + IDX_W'(1);
        if (complete && d_in) dval_q <= d_q + IDX_W'(1);
      end
      if (cmd_i.hi_clear) high_q <= '0;
      else if (cmd_i.hi_update && high_q < waddr_q) high_q <= waddr_q;
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign st_o.rx_lf     = (rx_q == CH_LF);
  assign st_o.cmd_full  = (cmd_cnt_q == LW'(LINE_CHARS));
  assign st_o.match_wr  = (cmd0_q == CH_W) && (cmd1_q == CH_R);
  assign st_o.match_dl  = (cmd0_q == CH_D) && (cmd1_q == CH_L);
  assign st_o.match_bw  = (cmd0_q == CH_B) && (cmd1_q == CH_W);
  assign st_o.rec_end   = (rec0_q == CH_E) && (rec1_q == CH_N) && (rec2_q == CH_D);
  assign st_o.rec_srec  = (rec0_q == CH_S) &&
                          (rec1_q == CH_1 || rec1_q == CH_2 || rec1_q == CH_3);
  assign st_o.s_done    = (s_q >= rec_cnt_q);
  assign st_o.char_zero = (rd_q == 8'h00);
  assign st_o.pending   = pend_q;
  assign st_o.sum_ok    = (sum_q[7:0] == 8'hFF);
  assign st_o.wr_more   = (i_q < {1'b0, len_q}) && (nwr_q < 6'(MAX_WRITES));
  assign st_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {6'h00, out_addr_q, out_byte_q, out_kind_q};

endmodule

// File: hdl/serial_srecord_loader.sv
// top level of the serial s-record loader: configuration registers, controller and datapath
// depends on ssl_pkg, ssl_ctrl and ssl_dp
//
// usage:
//  - s_axis carries one received serial byte per beat; m_axis carries result beats
//    (transmit byte, memory write or flash program request), tlast on the final
//    result caused by one input byte
//  - cfg channel writes ram_base (index 0) and ram_end (index 1); always ready,
//    write only while the block is idle
//  - one byte at a time: s_axis_tready is high only while no byte is in work
//  - a plain byte is taken, dispatched and then echoed; a line feed in download
//    mode walks the record line one character at a time (one read of the line
//    buffer, one decode step), then makes up to 62 memory writes (a check and
//    an emit each), followed by the acknowledge beats
//  - results leave through a single output register; a stalled receiver holds
//    the sequencer at the next result, nothing is dropped
//  - reset puts the loader in command mode with empty line buffers, ram_base 0
//    and ram_end all ones; no clearing pass is needed, fill counts mark the
//    valid part of each buffer
module serial_srecord_loader #(
  parameter int unsigned LINE_CHARS    = ssl_pkg::LINE_CHARS_DEF,
  parameter int unsigned DECODED_BYTES = ssl_pkg::DECODED_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // rx_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ssl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // kind, byte_value, address, zero pad
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);
  import ssl_pkg::*;

  logic [31:0] ram_base_q, ram_end_q;
  ctrl_cmd_t   cmd;
  dp_stat_t    st;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_base_q <= '0;
      ram_end_q  <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RAM_BASE: ram_base_q <= cfg_data_i;
        CFG_RAM_END:  ram_end_q  <= cfg_data_i;
        default:      ram_base_q <= ram_base_q;
      endcase
    end
  end

  // sequencer: mode and per-byte flow
  ssl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // buffers, decode, sum, write addresses and the output register
  ssl_dp #(
    .LINE_CHARS    (LINE_CHARS),
    .DECODED_BYTES (DECODED_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (s_axis_tdata),
    .ram_base_i  (ram_base_q),
    .ram_end_i   (ram_end_q),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// File: bench/serial_srecord_loader_test.sv
`timescale 1ns / 1ps
// self-checking bench for serial_srecord_loader: command echo, s-record download,
// flash request and sum errors, predicted in-bench; depends on ssl_pkg and the rtl
module serial_srecord_loader_test;
  import ssl_pkg::*;

  localparam int LC = LINE_CHARS_DEF;
  localparam int DB = DECODED_BYTES_DEF;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  val;
    logic [31:0] addr;
    logic        last;
  } loader_beat_t;

  typedef struct {
    string txt;
    bit    echoes;   // every char (line feed too) simply echoes back
  } line_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic [7:0] s_data = '0;
  logic s_axis_tready;
  logic m_axis_tvalid;
  logic m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  // beats still owed by the loader, oldest first
  loader_beat_t pending_beats[$];
  int errors = 0;
  int n_bytes = 0;
  int n_beats = 0;
  int n_writes = 0;
  int n_records = 0;
  int burst_left = 0;
  int rx_style = 0;
  bit long_hold = 1'b0;
  int hold_cnt = 0;

  // loader shadow state
  mode_e       ld_mode;
  logic [7:0]  cmd_buf[LC];
  int          cmd_fill;
  logic [7:0]  rec_buf[LC];
  int          rec_fill;
  logic [7:0]  hex_buf[DB];
  logic [31:0] top_addr;
  logic [31:0] base_reg;
  logic [31:0] end_reg;

  serial_srecord_loader u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void shadow_reset();
    ld_mode = MODE_WAIT;
    foreach (cmd_buf[i]) cmd_buf[i] = '0;
    foreach (rec_buf[i]) rec_buf[i] = '0;
    foreach (hex_buf[i]) hex_buf[i] = '0;
    cmd_fill = 0;
    rec_fill = 0;
    top_addr = '0;
    base_reg = '0;
    end_reg = '1;
  endfunction

  function automatic logic [7:0] hex_at(int unsigned i);
    return (i < DB) ? hex_buf[i] : 8'h00;
  endfunction

  function automatic void add_beat(ref loader_beat_t out[$], input logic [1:0] kind,
                                   input logic [7:0] val, input logic [31:0] addr);
    loader_beat_t b;
    b.kind = kind;
    b.val = val;
    b.addr = addr;
    b.last = 1'b0;
    if (out.size() < 64) out.push_back(b);
  endfunction

  // walks the record line on a line feed; returns 1 on a sum error
  function automatic bit decode_record(ref loader_beat_t out[$]);
    int unsigned abytes, d, length, writes;
    int unsigned sum;
    logic [31:0] addr;
    logic [7:0] c, nib;
    if (rec_buf[0] == CH_E && rec_buf[1] == CH_N && rec_buf[2] == CH_D) begin
      ld_mode = MODE_WAIT;
      return 1'b0;
    end
    if (rec_buf[0] != CH_S) return 1'b0;
    case (rec_buf[1])
      CH_1: abytes = 2;
      CH_2: abytes = 3;
      CH_3: abytes = 4;
      default: return 1'b0;
    endcase
    n_records++;
    foreach (hex_buf[i]) hex_buf[i] = '0;
    d = 0;
    for (int s = 2; s < LC && rec_buf[s] != 8'h00; s++) begin
      c = rec_buf[s];
      // letters count as low nibble plus nine, whatever the letter
      nib = (c < CH_UA) ? (c & 8'h0F) : ((c & 8'h0F) + 8'd9);
      if (s % 2 == 1) begin
        if (d < DB) hex_buf[d] = hex_buf[d] + nib;
        d++;
      end else if (d < DB) begin
        hex_buf[d] = nib << 4;
      end
    end
    length = hex_at(0);
    addr = '0;
    for (int unsigned i = 0; i < abytes; i++) addr = (addr << 8) | hex_at(i + 1);
    sum = 0;
    for (int unsigned i = 0; i <= length; i++) sum += hex_at(i);
    if (sum[7:0] != 8'hFF) begin
      add_beat(out, KIND_TX, sum[15:8], '0);
      add_beat(out, KIND_TX, sum[7:0], '0);
      return 1'b1;
    end
    addr = (addr & ADDR_MASK) + base_reg;
    writes = 0;
    for (int unsigned i = abytes + 1; i < length && writes < MAX_WRITES; i++) begin
      if (addr > end_reg) addr = end_reg;
      add_beat(out, KIND_WRITE, hex_at(i), addr);
      addr++;
      writes++;
      n_writes++;
    end
    if (top_addr < addr) top_addr = addr;
    return 1'b0;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, ref loader_beat_t out[$]);
    bit bad;
    case (ld_mode)
      MODE_WAIT: begin
        if (b == CH_LF) begin
          add_beat(out, KIND_TX, b, '0);
          if (cmd_buf[0] == CH_W && cmd_buf[1] == CH_R) ld_mode = MODE_WR;
          else if (cmd_buf[0] == CH_D && cmd_buf[1] == CH_L) ld_mode = MODE_DL;
          else if (cmd_buf[0] == CH_B && cmd_buf[1] == CH_W) ld_mode = MODE_BW;
          foreach (cmd_buf[i]) cmd_buf[i] = '0;
          cmd_fill = 0;
          if (ld_mode == MODE_DL) top_addr = '0;
        end else if (cmd_fill < LC) begin
          cmd_buf[cmd_fill] = b;
          cmd_fill++;
          add_beat(out, KIND_TX, b, '0);
        end
      end
      MODE_DL: begin
        if (b == CH_LF) begin
          bad = decode_record(out);
          foreach (rec_buf[i]) rec_buf[i] = '0;
          rec_fill = 0;
          if (bad) begin
            add_beat(out, KIND_TX, CH_LM, '0);
            ld_mode = MODE_WAIT;
          end else begin
            add_beat(out, KIND_TX, (ld_mode != MODE_DL) ? CH_LE : CH_LX, '0);
          end
          add_beat(out, KIND_TX, CH_LF, '0);
        end else if (rec_fill < LC) begin
          rec_buf[rec_fill] = b;
          rec_fill++;
        end
      end
      MODE_WR: begin
        add_beat(out, KIND_FLASH, 8'h00, top_addr - base_reg);
        add_beat(out, KIND_TX, CH_W, '0);
        add_beat(out, KIND_TX, CH_R, '0);
        add_beat(out, KIND_TX, CH_E, '0);
        add_beat(out, KIND_TX, CH_LF, '0);
        ld_mode = MODE_WAIT;
      end
      default: begin
        // boot write: silently back to command mode
        foreach (cmd_buf[i]) cmd_buf[i] = '0;
        cmd_fill = 0;
        ld_mode = MODE_WAIT;
      end
    endcase
    if (out.size() > 0) out[out.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- drivers

  // one beat on the rx side; bursts of random length with random gaps
  task automatic send_byte(input logic [7:0] b, input bit echoes);
    loader_beat_t got[$];
    loader_beat_t lit;
    if (burst_left == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 4) : $urandom_range(10, 40);
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data <= b;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    predict_byte(b, got);
    if (echoes) begin
      // plain echo, known without the predictor
      lit.kind = KIND_TX;
      lit.val = b;
      lit.addr = '0;
      lit.last = 1'b1;
      pending_beats.push_back(lit);
    end else begin
      foreach (got[i]) pending_beats.push_back(got[i]);
    end
    n_bytes++;
  endtask

  task automatic sender_stop();
    s_valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic send_chars(input logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], 1'b0);
  endtask

  task automatic wait_drained();
    sender_stop();
    do @(negedge clk_i); while (pending_beats.size() != 0);
    // a silent byte may still be in work
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == CFG_RAM_BASE) base_reg = val;
    else end_reg = val;
  endtask

  // ---------------------------------------------------------------- line builders

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'h30 + v;
    // either case decodes the same
    return (($urandom_range(0, 1) == 1) ? CH_UA : 8'h61) + v - 8'd10;
  endfunction

  function automatic logic [7:0] any_but_lf();
    logic [7:0] v;
    do v = $urandom_range(0, 255); while (v == CH_LF);
    return v;
  endfunction

  function automatic void push_hex(ref logic [7:0] q[$], input logic [7:0] v);
    q.push_back(hex_char(v[7:4]));
    q.push_back(hex_char(v[3:0]));
  endfunction

  // builds an s1/s2/s3 line; long_claim sets the length byte to 0xFF so the
  // write count runs into its limit
  function automatic void build_srec(ref logic [7:0] q[$], input int t, input int n,
                                     input bit bad, input bit long_claim);
    logic [7:0] body[$];
    logic [7:0] acc;
    int abytes = t + 1;
    if (long_claim) begin
      body.push_back(8'hFF);
      for (int i = 1; i < 62; i++) body.push_back($urandom_range(0, 255));
    end else begin
      body.push_back(abytes + n + 1);
      for (int i = 0; i < abytes + n; i++) body.push_back($urandom_range(0, 255));
    end
    acc = '0;
    foreach (body[i]) acc += body[i];
    acc = 8'hFF - acc;
    if (bad) acc ^= $urandom_range(1, 255);
    body.push_back(acc);
    q.push_back(CH_S);
    q.push_back(8'h30 + t);
    foreach (body[i]) push_hex(q, body[i]);
    q.push_back(CH_LF);
  endfunction

  function automatic void build_text(ref logic [7:0] q[$], input string s, input int tail);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    repeat (tail) q.push_back(any_but_lf());
    q.push_back(CH_LF);
  endfunction

  // one random step, shaped by the loader mode so that downloads go deep
  task automatic random_step();
    logic [7:0] q[$];
    int r;
    case (ld_mode)
      MODE_WAIT: begin
        r = $urandom_range(0, 9);
        if (r <= 3) build_text(q, "DL", $urandom_range(0, 2));
        else if (r == 4) build_text(q, "WR", $urandom_range(0, 2));
        else if (r == 5) build_text(q, "BW", $urandom_range(0, 2));
        else if (r == 6 && $urandom_range(0, 3) == 0) build_text(q, "", 135);
        else if (r <= 7) build_text(q, "", $urandom_range(0, 6));
        else build_text(q, "DL", 0);
      end
      MODE_DL: begin
        r = $urandom_range(0, 19);
        if (r == 11) begin
          build_srec(q, $urandom_range(1, 3), 0, 1'b0, 1'b1);
        end else if (r == 12 || r == 13) begin
          build_srec(q, $urandom_range(1, 3), $urandom_range(0, 6), 1'b1, 1'b0);
        end else if (r == 14) begin
          build_text(q, "END", $urandom_range(0, 2));
        end else if (r == 15) begin
          // junk, zero bytes and odd digit counts included
          if ($urandom_range(0, 1) == 1) build_text(q, "S1", $urandom_range(0, 20));
          else build_text(q, "", $urandom_range(0, 20));
        end else if (r == 16) begin
          build_text(q, "S1", 140);
        end else begin
          r = $urandom_range(1, 3);
          build_srec(q, r, ($urandom_range(0, 5) == 0) ? 60 - r : $urandom_range(0, 8),
                     1'b0, 1'b0);
        end
      end
      default: q.push_back($urandom_range(0, 255));
    endcase
    send_chars(q);
  endtask

  // ---------------------------------------------------------------- receiver side

  always @(posedge clk_i) begin
    if (long_hold) begin
      // long stall, counted here, so the single output register backs up
      m_ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= 400) begin
        long_hold <= 1'b0;
        hold_cnt <= 0;
      end
    end else begin
      if ($urandom_range(0, 63) == 0) rx_style <= $urandom_range(0, 2);
      case (rx_style)
        0: m_ready <= 1'b1;
        1: m_ready <= ($urandom_range(0, 1) == 1);
        default: m_ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // beat is taken at the next rising edge; signals are stable here
  always @(negedge clk_i) begin
    loader_beat_t exp_b;
    if (rst_ni && m_axis_tvalid && m_ready) begin
      n_beats++;
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, tdata %h tlast %b", $time, m_axis_tdata,
                 m_axis_tlast);
      end else begin
        exp_b = pending_beats.pop_front();
        if (m_axis_tdata[1:0] != exp_b.kind) begin
          errors++;
          $display("%0t: kind expected %0d actual %0d", $time, exp_b.kind,
                   m_axis_tdata[1:0]);
        end
        if (m_axis_tdata[9:2] != exp_b.val) begin
          errors++;
          $display("%0t: byte expected %h actual %h", $time, exp_b.val, m_axis_tdata[9:2]);
        end
        if (m_axis_tdata[41:10] != exp_b.addr) begin
          errors++;
          $display("%0t: address expected %h actual %h", $time, exp_b.addr,
                   m_axis_tdata[41:10]);
        end
        if (m_axis_tlast != exp_b.last) begin
          errors++;
          $display("%0t: tlast expected %b actual %b", $time, exp_b.last, m_axis_tlast);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  line_row_t directed[] = '{
    '{"AZ\377~\n", 1'b1},
    '{"BW\n", 1'b1},
    '{"q", 1'b0},
    '{"DL\n", 1'b1},
    '{"S1130000285F245F2212226A000424290008237C2A\n", 1'b0},
    '{"S2080100000102037A\n", 1'b0},
    '{"S5030000FC\n", 1'b0},
    '{"S1030000FC\n", 1'b0},
    '{"END\n", 1'b0},
    '{"WR\n", 1'b1},
    '{"z", 1'b0},
    '{"DL\n", 1'b1},
    '{"S10300001\n", 1'b0},
    '{"BW\n", 1'b1},
    '{"\n", 1'b0}
  };

  logic [31:0] base_set[4] = '{32'h0000_0000, 32'h0000_0100, 32'hFFFF_FFFF, 32'h0};
  logic [31:0] end_set[4]  = '{32'hFFFF_FFFF, 32'h0000_01FF, 32'h0000_0000, 32'h0};

  initial begin
    string s;
    shadow_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed lines under reset values
    foreach (directed[r]) begin
      s = directed[r].txt;
      for (int i = 0; i < s.len(); i++) send_byte(s[i], directed[r].echoes);
    end

    end_set[3] = $urandom();
    base_set[3] = $urandom();
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_reg(CFG_RAM_BASE, base_set[ph]);
      write_reg(CFG_RAM_END, end_set[ph]);
      for (int k = 0; k < 30; k++) begin
        if (ph == 1 && k == 3) long_hold = 1'b1;
        if (ph == 2 && k == 15) wait_drained();
        random_step();
      end
    end

    sender_stop();
    do @(negedge clk_i); while (pending_beats.size() != 0);
    repeat (600) @(posedge clk_i);
    $display("covered %0d rx bytes, %0d result beats, %0d records, %0d memory writes",
             n_bytes, n_beats, n_records, n_writes);
    $display("four ram_base/ram_end settings incl. extremes, long stall and drained pauses");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
